[sv/lls_pkg.sv]
// ----------------------------------------------------------------------------
// lls_pkg: shared types and constants of the lift level stepper
// command codes, phase codes, fault codes, register map and reset values
// ----------------------------------------------------------------------------
package lls_pkg;

	localparam int MAX_LEVELS_DEF = 8;
	localparam int TIMER_BITS_DEF = 16;

	localparam int KIND_W  = 3;
	localparam int LVL_W   = 5;
	localparam int DRIVE_W = 9;
	localparam int SPEED_W = 8;
	localparam int STAB_W  = 8;
	localparam int TOUT_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// reset values of the configuration registers
	localparam logic [STAB_W-1:0]  STABLE_SAMPLES_RST  = 8'd5;
	localparam logic [TOUT_W-1:0]  PHASE_TIMEOUT_RST   = 16'd1000;
	localparam logic [TOUT_W-1:0]  HOME_TIMEOUT_RST    = 16'd3000;
	localparam logic [SPEED_W-1:0] UP_SPEED_RST        = 8'd128;
	localparam logic [SPEED_W-1:0] DOWN_SPEED_RST      = 8'd96;
	localparam logic [SPEED_W-1:0] OVR_UP_SPEED_RST    = 8'd128;
	localparam logic [SPEED_W-1:0] OVR_DOWN_SPEED_RST  = 8'd96;

	// pending task encoding: signed level count, or the home marker
	localparam logic [LVL_W-1:0] TASK_NONE = 5'd0;
	localparam logic [LVL_W-1:0] TASK_HOME = 5'd16;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK     = 3'd0,
		KIND_MOVE     = 3'd1,
		KIND_HOME     = 3'd2,
		KIND_OVR_UP   = 3'd3,
		KIND_OVR_DOWN = 3'd4,
		KIND_OVR_STOP = 3'd5,
		KIND_OVR_END  = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_LEAVE = 2'd1,
		PH_SEEK  = 2'd2,
		PH_HOME  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		FAULT_NONE  = 2'd0,
		FAULT_LEAVE = 2'd1,
		FAULT_SEEK  = 2'd2,
		FAULT_HOME  = 2'd3
	} fault_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STABLE_SAMPLES = 3'd0,
		REG_PHASE_TIMEOUT  = 3'd1,
		REG_HOME_TIMEOUT   = 3'd2,
		REG_UP_SPEED       = 3'd3,
		REG_DOWN_SPEED     = 3'd4,
		REG_OVR_UP_SPEED   = 3'd5,
		REG_OVR_DOWN_SPEED = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [STAB_W-1:0]  stable_samples;
		logic [TOUT_W-1:0]  phase_timeout_ticks;
		logic [TOUT_W-1:0]  home_timeout_ticks;
		logic [SPEED_W-1:0] up_speed;
		logic [SPEED_W-1:0] down_speed;
		logic [SPEED_W-1:0] override_up_speed;
		logic [SPEED_W-1:0] override_down_speed;
	} cfg_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] motor_drive;
		logic                      gate_open;
		logic                      busy_res;
		fault_t                    fault;
	} res_t;

endpackage

[sv/lls_cfg.sv]
// ----------------------------------------------------------------------------
// lls_cfg: configuration register file
// seven write-only registers loaded from the plain write port
// ----------------------------------------------------------------------------
module lls_cfg
	import lls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stable_samples      <= STABLE_SAMPLES_RST;
			cfg_q.phase_timeout_ticks <= PHASE_TIMEOUT_RST;
			cfg_q.home_timeout_ticks  <= HOME_TIMEOUT_RST;
			cfg_q.up_speed            <= UP_SPEED_RST;
			cfg_q.down_speed          <= DOWN_SPEED_RST;
			cfg_q.override_up_speed   <= OVR_UP_SPEED_RST;
			cfg_q.override_down_speed <= OVR_DOWN_SPEED_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				REG_STABLE_SAMPLES: cfg_q.stable_samples <= cfg_data[STAB_W-1:0];
				REG_PHASE_TIMEOUT:  cfg_q.phase_timeout_ticks <= cfg_data[TOUT_W-1:0];
				REG_HOME_TIMEOUT:   cfg_q.home_timeout_ticks <= cfg_data[TOUT_W-1:0];
				REG_UP_SPEED:       cfg_q.up_speed <= cfg_data[SPEED_W-1:0];
				REG_DOWN_SPEED:     cfg_q.down_speed <= cfg_data[SPEED_W-1:0];
				REG_OVR_UP_SPEED:   cfg_q.override_up_speed <= cfg_data[SPEED_W-1:0];
				REG_OVR_DOWN_SPEED: cfg_q.override_down_speed <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/lls_core.sv]
// ----------------------------------------------------------------------------
// lls_core: lift sequencer state and single-pass step logic
// applies one request to the sequencer state and forms its result
// ----------------------------------------------------------------------------
module lls_core
	import lls_pkg::*;
#(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              step,
	input  logic [KIND_W-1:0] kind,
	input  logic signed [LVL_W-1:0] level_delta,
	input  logic              beam_blocked,
	input  logic              top_limit,
	input  logic              bottom_limit,
	output res_t              res
);

	localparam int CMP_W = (TIMER_BITS > TOUT_W) ? TIMER_BITS : TOUT_W;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
	localparam logic signed [LVL_W-1:0] MAX_S = LVL_W'(MAX_LEVELS);
	localparam logic signed [LVL_W-1:0] ONE_S = LVL_W'(1);
	localparam logic [STAB_W-1:0] STAB_MAX = {STAB_W{1'b1}};

	phase_t                    phase_q, phase_d;
	logic signed [LVL_W-1:0]   levels_q, levels_d;
	logic [LVL_W-1:0]          pend_q, pend_d;
	logic [STAB_W-1:0]         stab_q, stab_d;
	logic [TIMER_BITS-1:0]     ticks_q, ticks_d;
	logic                      ovr_q, ovr_d;
	logic                      busy_q, busy_d;
	logic signed [DRIVE_W-1:0] drive_q, drive_d;
	logic                      gate_q, gate_d;
	fault_t                    fault;

	logic                      up, lim_hit, want, stab_done;
	logic [TIMER_BITS-1:0]     tick_inc;
	logic [STAB_W-1:0]         stab_inc;
	logic                      home_to, phase_to;
	logic signed [LVL_W-1:0]   lv_next, delta_sat;
	logic                      do_start, st_up;
	logic signed [LVL_W-1:0]   start_lv;
	logic signed [DRIVE_W-1:0] up_drive, down_drive;

	// shared datapath pieces
	always_comb begin
		up       = (levels_q > 0);
		lim_hit  = up ? top_limit : bottom_limit;
		tick_inc = (ticks_q != TMAX) ? ticks_q + 1'b1 : ticks_q;
		home_to  = (CMP_W'(tick_inc) >= CMP_W'(cfg.home_timeout_ticks)) || (tick_inc == TMAX);
		phase_to = (CMP_W'(tick_inc) >= CMP_W'(cfg.phase_timeout_ticks)) || (tick_inc == TMAX);
		want     = (phase_q == PH_LEAVE) ? !beam_blocked : beam_blocked;
		if (!want)
			stab_inc = '0;
		else if (stab_q != STAB_MAX)
			stab_inc = stab_q + 1'b1;
		else
			stab_inc = stab_q;
		stab_done = (stab_inc > cfg.stable_samples);
		lv_next   = up ? levels_q - ONE_S : levels_q + ONE_S;
		if (level_delta > MAX_S)
			delta_sat = MAX_S;
		else if (level_delta < -MAX_S)
			delta_sat = -MAX_S;
		else
			delta_sat = level_delta;
		up_drive   = $signed({1'b0, cfg.up_speed});
		down_drive = -$signed({1'b0, cfg.down_speed});
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		levels_d = levels_q;
		pend_d   = pend_q;
		stab_d   = stab_q;
		ticks_d  = ticks_q;
		ovr_d    = ovr_q;
		busy_d   = busy_q;
		drive_d  = drive_q;
		gate_d   = gate_q;
		fault    = FAULT_NONE;
		do_start = 1'b0;
		start_lv = '0;
		st_up    = 1'b0;

		case (kind_t'(kind))
			KIND_TICK: begin
				case (phase_q)
					PH_IDLE: begin
						if (pend_q == TASK_HOME) begin
							pend_d  = TASK_NONE;
							phase_d = PH_HOME;
							ticks_d = '0;
							drive_d = down_drive;
							gate_d  = 1'b1;
						end else if (pend_q != TASK_NONE) begin
							pend_d   = TASK_NONE;
							do_start = 1'b1;
							start_lv = $signed(pend_q);
						end
					end
					PH_HOME: begin
						ticks_d = tick_inc;
						if (bottom_limit || home_to) begin
							if (!bottom_limit)
								fault = FAULT_HOME;
							else
								ticks_d = ticks_q;
							phase_d  = PH_IDLE;
							levels_d = '0;
							drive_d  = '0;
							gate_d   = 1'b0;
							busy_d   = 1'b0;
						end
					end
					default: begin
						if (lim_hit) begin
							phase_d  = PH_IDLE;
							levels_d = '0;
							drive_d  = '0;
							gate_d   = 1'b0;
							busy_d   = 1'b0;
						end else begin
							stab_d  = stab_inc;
							ticks_d = tick_inc;
							if (stab_done || phase_to) begin
								if (!stab_done)
									fault = (phase_q == PH_LEAVE) ? FAULT_LEAVE : FAULT_SEEK;
								stab_d  = '0;
								ticks_d = '0;
								if (phase_q == PH_LEAVE) begin
									phase_d = PH_SEEK;
								end else begin
									do_start = 1'b1;
									start_lv = lv_next;
								end
							end
						end
					end
				endcase
			end
			KIND_MOVE: begin
				if (!ovr_q && phase_q == PH_IDLE && level_delta != 0) begin
					pend_d = $unsigned(delta_sat);
					busy_d = 1'b1;
				end
			end
			KIND_HOME: begin
				if (!ovr_q && phase_q == PH_IDLE) begin
					pend_d = TASK_HOME;
					busy_d = 1'b1;
				end
			end
			KIND_OVR_UP, KIND_OVR_DOWN: begin
				phase_d  = PH_IDLE;
				levels_d = '0;
				pend_d   = TASK_NONE;
				ovr_d    = 1'b1;
				busy_d   = 1'b1;
				gate_d   = 1'b1;
				if (kind_t'(kind) == KIND_OVR_UP)
					drive_d = $signed({1'b0, cfg.override_up_speed});
				else
					drive_d = -$signed({1'b0, cfg.override_down_speed});
			end
			KIND_OVR_STOP: begin
				phase_d  = PH_IDLE;
				levels_d = '0;
				pend_d   = TASK_NONE;
				ovr_d    = 1'b1;
				drive_d  = '0;
				gate_d   = 1'b0;
			end
			KIND_OVR_END: begin
				if (ovr_q) begin
					ovr_d   = 1'b0;
					busy_d  = 1'b0;
					drive_d = '0;
					gate_d  = 1'b0;
				end
			end
			default: ;
		endcase

		// start the next level of a move, or end the move
		if (do_start) begin
			st_up = (start_lv > 0);
			if (start_lv == 0 || (st_up && top_limit) || (!st_up && bottom_limit)) begin
				phase_d  = PH_IDLE;
				levels_d = '0;
				drive_d  = '0;
				gate_d   = 1'b0;
				busy_d   = 1'b0;
			end else begin
				phase_d  = PH_LEAVE;
				levels_d = start_lv;
				stab_d   = '0;
				ticks_d  = '0;
				drive_d  = st_up ? up_drive : down_drive;
				gate_d   = 1'b1;
			end
		end
	end

	// outputs of the step
	always_comb begin
		res.motor_drive = drive_d;
		res.gate_open   = gate_d;
		res.busy_res    = busy_d;
		res.fault       = fault;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			levels_q <= '0;
			pend_q   <= TASK_NONE;
			stab_q   <= '0;
			ticks_q  <= '0;
			ovr_q    <= 1'b0;
			busy_q   <= 1'b0;
			drive_q  <= '0;
			gate_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			levels_q <= levels_d;
			pend_q   <= pend_d;
			stab_q   <= stab_d;
			ticks_q  <= ticks_d;
			ovr_q    <= ovr_d;
			busy_q   <= busy_d;
			drive_q  <= drive_d;
			gate_q   <= gate_d;
		end
	end

endmodule

[sv/lls_out_buf.sv]
// ----------------------------------------------------------------------------
// lls_out_buf: result register with skid stage
// holds up to two results so the input side stall comes from a register
// ----------------------------------------------------------------------------
module lls_out_buf
	import lls_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_res
);

	logic main_valid_q, skid_valid_q;
	res_t main_q, skid_q;
	logic pop;

	assign pop = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_res;
		end else if (push) begin
			if (main_valid_q)
				skid_q <= push_res;
			else
				main_q <= push_res;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

endmodule

[sv/lift_level_stepper.sv]
// ----------------------------------------------------------------------------
// lift_level_stepper: lift sequencer top level
// result path: a request's result is registered in the main result register when it is free, else in the skid entry
// throughput: one request per cycle while the skid entry is free; the step logic updates all state in one pass
// stall comes from the skid register only, so input and output sides are decoupled
// reset: async active low; lift idle, no override, registers at their defaults
// ----------------------------------------------------------------------------
module lift_level_stepper
	import lls_pkg::*;
#(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	// request channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [KIND_W-1:0]         kind,
	input  logic signed [LVL_W-1:0]   level_delta,
	input  logic                      beam_blocked,
	input  logic                      top_limit,
	input  logic                      bottom_limit,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DRIVE_W-1:0] motor_drive,
	output logic                      gate_open,
	output logic                      busy_res,
	output logic [1:0]                fault
);

	cfg_t cfg;
	res_t step_res, out_res;
	logic buf_full;
	logic step;

	// a request is taken whenever the skid stage is free
	assign in_stall = buf_full;
	assign step     = in_valid && !buf_full;

	// register file for thresholds, timeouts and speeds
	lls_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: leave/seek phases per level, homing, override
	lls_core #(
		.MAX_LEVELS (MAX_LEVELS),
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.step         (step),
		.kind         (kind),
		.level_delta  (level_delta),
		.beam_blocked (beam_blocked),
		.top_limit    (top_limit),
		.bottom_limit (bottom_limit),
		.res          (step_res)
	);

	// result register plus skid entry
	lls_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_res  (step_res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	// unpack result fields onto their ports
	assign motor_drive = out_res.motor_drive;
	assign gate_open   = out_res.gate_open;
	assign busy_res    = out_res.busy_res;
	assign fault       = out_res.fault;

endmodule

[bench/tb_lift_level_stepper.sv]
// ----------------------------------------------------------------------------
// tb_lift_level_stepper: self-checking bench for the lift sequencer
// a directed table covers the reset state, command acceptance rules, limit
// stops, homing and override; then random request streams shaped by the
// bench's own lift predictor run under several register settings, with
// random idling and stalls on both channels and one long output hold-off
// ----------------------------------------------------------------------------
module tb_lift_level_stepper;
	import lls_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;   // unused code, must change nothing
	localparam int TIMER_TOP = (1 << TIMER_BITS_DEF) - 1;
	localparam int N_DIR = 26;
	localparam int N_PLAN = 5;

	// dut ports; every input known from time zero
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [KIND_W-1:0]         kind = KIND_TICK;
	logic signed [LVL_W-1:0]   level_delta = '0;
	logic                      beam_blocked = 1'b0;
	logic                      top_limit = 1'b0;
	logic                      bottom_limit = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [DRIVE_W-1:0] motor_drive;
	logic                      gate_open;
	logic                      busy_res;
	logic [1:0]                fault;

	lift_level_stepper u_dut (.*);

	// directed row: one request, plus a hand-typed result where it is obvious
	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [LVL_W-1:0]   delta;
		logic                      beam;
		logic                      top;
		logic                      bot;
		logic                      typed;
		logic signed [DRIVE_W-1:0] drive;
		logic                      gate;
		logic                      busy;
		fault_t                    flt;
	} dir_row_t;

	// columns: kind, delta, beam, top, bottom, typed, drive, gate, busy, fault
	dir_row_t dir_rows [N_DIR] = '{
		'{KIND_TICK,     0,   0, 0, 0, 1,   0, 0, 0, FAULT_NONE},  // reset outputs
		'{KIND_SPARE,    -16, 1, 1, 1, 1,   0, 0, 0, FAULT_NONE},  // unused code is a no-op
		'{KIND_OVR_END,  0,   0, 0, 0, 1,   0, 0, 0, FAULT_NONE},  // end override while off
		'{KIND_MOVE,     15,  0, 0, 0, 1,   0, 0, 1, FAULT_NONE},  // saturates to +8
		'{KIND_TICK,     0,   0, 1, 0, 1,   0, 0, 0, FAULT_NONE},  // top closed at start
		'{KIND_MOVE,     -16, 0, 0, 0, 1,   0, 0, 1, FAULT_NONE},  // saturates to -8
		'{KIND_TICK,     0,   1, 1, 0, 1, -96, 1, 1, FAULT_NONE},  // down, top ignored
		'{KIND_TICK,     0,   0, 0, 0, 0,   0, 0, 0, FAULT_NONE},
		'{KIND_MOVE,     3,   0, 0, 0, 0,   0, 0, 0, FAULT_NONE},  // ignored while moving
		'{KIND_HOME,     0,   0, 0, 0, 0,   0, 0, 0, FAULT_NONE},  // ignored while moving
		'{KIND_TICK,     0,   0, 0, 1, 1,   0, 0, 0, FAULT_NONE},  // bottom stops the move
		'{KIND_MOVE,     0,   1, 1, 1, 1,   0, 0, 0, FAULT_NONE},  // zero delta ignored
		'{KIND_HOME,     0,   0, 0, 0, 1,   0, 0, 1, FAULT_NONE},
		'{KIND_TICK,     0,   0, 0, 1, 1, -96, 1, 1, FAULT_NONE},  // homing starts anyway
		'{KIND_TICK,     0,   1, 0, 0, 0,   0, 0, 0, FAULT_NONE},
		'{KIND_TICK,     0,   0, 0, 1, 1,   0, 0, 0, FAULT_NONE},  // home reached
		'{KIND_OVR_UP,   0,   0, 0, 0, 1, 128, 1, 1, FAULT_NONE},
		'{KIND_MOVE,     1,   0, 0, 0, 0,   0, 0, 0, FAULT_NONE},  // ignored in override
		'{KIND_OVR_DOWN, 0,   0, 0, 0, 1, -96, 1, 1, FAULT_NONE},
		'{KIND_OVR_STOP, 0,   0, 0, 0, 1,   0, 0, 1, FAULT_NONE},  // busy kept
		'{KIND_HOME,     0,   0, 0, 0, 0,   0, 0, 0, FAULT_NONE},  // ignored in override
		'{KIND_OVR_END,  0,   0, 0, 0, 1,   0, 0, 0, FAULT_NONE},
		'{KIND_MOVE,     1,   0, 0, 0, 1,   0, 0, 1, FAULT_NONE},
		'{KIND_TICK,     0,   1, 0, 1, 1, 128, 1, 1, FAULT_NONE},  // up, bottom ignored
		'{KIND_OVR_STOP, 0,   0, 0, 0, 1,   0, 0, 1, FAULT_NONE},  // drops the move
		'{KIND_OVR_END,  0,   0, 0, 0, 1,   0, 0, 0, FAULT_NONE}
	};

	// predictor copy of the lift state and registers
	cfg_t cfg_m = '{STABLE_SAMPLES_RST, PHASE_TIMEOUT_RST, HOME_TIMEOUT_RST, UP_SPEED_RST,
		DOWN_SPEED_RST, OVR_UP_SPEED_RST, OVR_DOWN_SPEED_RST};
	phase_t           ph = PH_IDLE;
	int               lvl_left = 0;
	logic [LVL_W-1:0] pend = TASK_NONE;
	int               stab_cnt = 0;
	int               ph_ticks = 0;
	bit               ovr_on = 1'b0;
	bit               busy_q = 1'b0;
	bit               gate_q = 1'b0;
	int               drive_q = 0;

	res_t lift_out_q [$];      // expected outputs, oldest first

	// run control and statistics
	bit idle_on = 1'b1;        // random gaps and stalls allowed
	bit stuck = 1'b0;          // current task gets sensor samples that fight it
	int long_hold = 0;         // hold-off length requested from the result sink
	int n_req = 0;
	int n_res = 0;
	int n_err = 0;
	int n_settings = 0;
	int n_levels = 0;
	int n_homes = 0;
	int n_holds = 0;
	int fault_hits [4] = '{0, 0, 0, 0};

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// lift predictor
	// ------------------------------------------------------------------------
	task automatic go_idle();
		ph = PH_IDLE;
		lvl_left = 0;
		drive_q = 0;
		gate_q = 1'b0;
		busy_q = 1'b0;
	endtask

	// next level of a move, or the end of it; a limit in the travel direction stops it
	task automatic begin_level(input logic top, input logic bot);
		bit up;
		up = lvl_left > 0;
		if (lvl_left == 0 || (up && top) || (!up && bot)) begin
			go_idle();
		end else begin
			ph = PH_LEAVE;
			stab_cnt = 0;
			ph_ticks = 0;
			drive_q = up ? int'(cfg_m.up_speed) : -int'(cfg_m.down_speed);
			gate_q = 1'b1;
			n_levels++;
		end
	endtask

	// phase timer saturates; saturation counts as a timeout
	function automatic bit tick_timer(input int lim);
		if (ph_ticks < TIMER_TOP)
			ph_ticks++;
		return ph_ticks >= lim || ph_ticks == TIMER_TOP;
	endfunction

	task automatic lift_predict(input logic [KIND_W-1:0] k, input logic signed [LVL_W-1:0] d,
			input logic beam, input logic top, input logic bot, output res_t r);
		int delta;
		fault_t f;
		bit up;
		bit want;
		bit timed;
		f = FAULT_NONE;
		delta = int'(d);
		case (k)
			KIND_TICK: begin
				if (ph == PH_IDLE) begin
					// pending task starts; samples only feed the limit check
					if (pend == TASK_HOME) begin
						pend = TASK_NONE;
						ph = PH_HOME;
						ph_ticks = 0;
						drive_q = -int'(cfg_m.down_speed);
						gate_q = 1'b1;
						n_homes++;
					end else if (pend != TASK_NONE) begin
						lvl_left = int'($signed(pend));
						pend = TASK_NONE;
						begin_level(top, bot);
					end
				end else if (ph == PH_HOME) begin
					if (bot) begin
						go_idle();
					end else if (tick_timer(int'(cfg_m.home_timeout_ticks))) begin
						f = FAULT_HOME;
						go_idle();
					end
				end else begin
					up = lvl_left > 0;
					if ((up && top) || (!up && bot)) begin
						go_idle();
					end else begin
						// leave wants the beam clear, seek wants it blocked
						want = (ph == PH_LEAVE) ? !beam : beam;
						if (!want)
							stab_cnt = 0;
						else if (stab_cnt < 255)
							stab_cnt++;
						timed = tick_timer(int'(cfg_m.phase_timeout_ticks));
						if (stab_cnt > int'(cfg_m.stable_samples) || timed) begin
							if (stab_cnt <= int'(cfg_m.stable_samples))
								f = (ph == PH_LEAVE) ? FAULT_LEAVE : FAULT_SEEK;
							stab_cnt = 0;
							ph_ticks = 0;
							if (ph == PH_LEAVE) begin
								ph = PH_SEEK;
							end else begin
								lvl_left += up ? -1 : 1;
								begin_level(top, bot);
							end
						end
					end
				end
			end
			KIND_MOVE: begin
				if (!ovr_on && ph == PH_IDLE && delta != 0) begin
					if (delta > MAX_LEVELS_DEF)
						delta = MAX_LEVELS_DEF;
					if (delta < -MAX_LEVELS_DEF)
						delta = -MAX_LEVELS_DEF;
					pend = LVL_W'(delta);
					busy_q = 1'b1;
				end
			end
			KIND_HOME: begin
				if (!ovr_on && ph == PH_IDLE) begin
					pend = TASK_HOME;
					busy_q = 1'b1;
				end
			end
			KIND_OVR_UP, KIND_OVR_DOWN, KIND_OVR_STOP: begin
				// any override drops running and pending tasks
				ph = PH_IDLE;
				lvl_left = 0;
				pend = TASK_NONE;
				ovr_on = 1'b1;
				if (k == KIND_OVR_STOP) begin
					drive_q = 0;
					gate_q = 1'b0;
				end else begin
					busy_q = 1'b1;
					gate_q = 1'b1;
					drive_q = (k == KIND_OVR_UP) ? int'(cfg_m.override_up_speed)
						: -int'(cfg_m.override_down_speed);
				end
			end
			KIND_OVR_END: begin
				if (ovr_on) begin
					ovr_on = 1'b0;
					busy_q = 1'b0;
					drive_q = 0;
					gate_q = 1'b0;
				end
			end
			default: ;
		endcase
		r.motor_drive = DRIVE_W'(drive_q);
		r.gate_open = gate_q;
		r.busy_res = busy_q;
		r.fault = f;
		fault_hits[f]++;
	endtask

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------
	task automatic flag_error(input string what);
		n_err++;
		if (n_err <= 10)
			$display("[%0t] ERROR %s", $realtime, what);
	endtask

	// offer one request, hold it until taken, then record what should come out
	task automatic send_req(input logic [KIND_W-1:0] k, input logic signed [LVL_W-1:0] d,
			input logic b, input logic t, input logic bt, input bit typed, input res_t typed_res);
		res_t r;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		level_delta <= d;
		beam_blocked <= b;
		top_limit <= t;
		bottom_limit <= bt;
		do @(posedge clk); while (in_stall);
		lift_predict(k, d, b, t, bt, r);
		lift_out_q.push_back(typed ? typed_res : r);
		n_req++;
	endtask

	// wait until every expected result is back; valid drops here
	task automatic drain_results();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (lift_out_q.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	// write all seven registers, one per clock
	task automatic load_regs(input cfg_t c);
		logic [CFG_DATA_W-1:0] v;
		for (int i = 0; i <= int'(REG_OVR_DOWN_SPEED); i++) begin
			case (cfg_idx_t'(i))
				REG_STABLE_SAMPLES: v = CFG_DATA_W'(c.stable_samples);
				REG_PHASE_TIMEOUT:  v = c.phase_timeout_ticks;
				REG_HOME_TIMEOUT:   v = c.home_timeout_ticks;
				REG_UP_SPEED:       v = CFG_DATA_W'(c.up_speed);
				REG_DOWN_SPEED:     v = CFG_DATA_W'(c.down_speed);
				REG_OVR_UP_SPEED:   v = CFG_DATA_W'(c.override_up_speed);
				default:            v = CFG_DATA_W'(c.override_down_speed);
			endcase
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= v;
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		cfg_m = c;
		n_settings++;
	endtask

	// random requests steered by the predicted lift state: mostly complete
	// moves and homing runs with realistic sensor samples, plus noise
	task automatic run_random(input int n, input int hold_at);
		logic [KIND_W-1:0] k;
		logic signed [LVL_W-1:0] d;
		logic b;
		logic t;
		logic bt;
		int roll;
		int good;
		bit up;
		bit homing;
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				long_hold = 300;
			roll = $urandom_range(0, 99);
			d = LVL_W'($urandom);
			b = 1'($urandom_range(0, 1));
			t = 1'($urandom_range(0, 1));
			bt = 1'($urandom_range(0, 1));
			k = KIND_TICK;
			if (ovr_on) begin
				if (roll < 30)
					k = KIND_OVR_END;
				else if (roll < 45)
					k = KIND_W'($urandom_range(int'(KIND_OVR_UP), int'(KIND_OVR_STOP)));
				else if (roll < 60)
					k = KIND_W'($urandom_range(int'(KIND_MOVE), int'(KIND_HOME)));
			end else if (ph == PH_IDLE && pend == TASK_NONE) begin
				// lift at rest: start something most of the time
				if (roll < 60)
					k = KIND_MOVE;
				else if (roll < 78)
					k = KIND_HOME;
				else if (roll < 84)
					k = KIND_W'($urandom_range(int'(KIND_OVR_UP), int'(KIND_OVR_STOP)));
				else if (roll < 88)
					k = KIND_SPARE;
				else if (roll < 92)
					k = KIND_OVR_END;
				stuck = ($urandom_range(0, 4) == 0);
			end else if (ph == PH_IDLE) begin
				// pending task: a new command replaces it
				if (roll < 8)
					k = KIND_MOVE;
				else if (roll < 10)
					k = KIND_HOME;
			end else begin
				if (roll < 3)
					k = KIND_W'($urandom_range(int'(KIND_OVR_UP), int'(KIND_OVR_STOP)));
				else if (roll < 5)
					k = KIND_W'($urandom_range(int'(KIND_MOVE), int'(KIND_HOME)));
				else if (roll < 6)
					k = KIND_SPARE;
			end

			// short moves mostly; the rest covers zero and saturating deltas
			if (k == KIND_MOVE && $urandom_range(0, 9) < 7) begin
				roll = $urandom_range(1, 3);
				d = $urandom_range(0, 1) ? LVL_W'(-roll) : LVL_W'(roll);
			end

			if (k == KIND_TICK) begin
				good = stuck ? 10 : 88;
				homing = (ph == PH_HOME) || (ph == PH_IDLE && pend == TASK_HOME);
				if (ph == PH_IDLE)
					up = (pend != TASK_HOME) && !pend[LVL_W-1];
				else
					up = lvl_left > 0;
				if (ph == PH_LEAVE)
					b = ($urandom_range(0, 99) < good) ? 1'b0 : 1'b1;
				else if (ph == PH_SEEK)
					b = ($urandom_range(0, 99) < good) ? 1'b1 : 1'b0;
				// limit in the travel direction stays rare so moves get far
				if (homing) begin
					bt = ($urandom_range(0, 99) < (stuck ? 1 : 12));
				end else if (ph != PH_IDLE || pend != TASK_NONE) begin
					if (up)
						t = ($urandom_range(0, 99) < 3);
					else
						bt = ($urandom_range(0, 99) < 3);
				end
			end
			send_req(k, d, b, t, bt, 1'b0, '0);
		end
		// park the lift so the next register setting starts from rest
		send_req(KIND_OVR_STOP, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
		send_req(KIND_OVR_END, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
	endtask

	// ------------------------------------------------------------------------
	// result side: random stall bursts, plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int n;
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				n = long_hold;
				long_hold = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				n_holds++;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare every taken result with the oldest expectation
	always @(posedge clk) begin : result_check
		res_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			n_res++;
			if (lift_out_q.size() == 0) begin
				flag_error($sformatf("result %0d arrived with nothing expected", n_res));
			end else begin
				exp_res = lift_out_q.pop_front();
				if (motor_drive !== exp_res.motor_drive || gate_open !== exp_res.gate_open ||
						busy_res !== exp_res.busy_res || fault !== exp_res.fault)
					flag_error($sformatf(
						"result %0d: drive %0d/%0d gate %0b/%0b busy %0b/%0b fault %0d/%0d (exp/got)",
						n_res, exp_res.motor_drive, motor_drive, exp_res.gate_open, gate_open,
						exp_res.busy_res, busy_res, exp_res.fault, fault));
			end
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		cfg_t plan [N_PLAN];
		// stable, phase timeout, home timeout, up, down, override up, override down
		plan[0] = '{8'd2, 16'd12, 16'd20, 8'd200, 8'd50, 8'd255, 8'd1};
		plan[1] = '{8'd0, 16'd0, 16'd0, 8'd0, 8'd255, 8'd0, 8'd255};      // zero timeouts
		plan[2] = '{8'd255, 16'd6, 16'd9, 8'd255, 8'd0, 8'd17, 8'd33};    // timeout only
		plan[3] = '{8'd3, 16'd65535, 16'd65535, 8'd1, 8'd128, 8'd128, 8'd128};
		plan[4] = '{8'($urandom_range(0, 4)), 16'($urandom_range(1, 20)),
			16'($urandom_range(1, 30)), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run on the reset register values
		for (int i = 0; i < N_DIR; i++)
			send_req(dir_rows[i].kind, dir_rows[i].delta, dir_rows[i].beam, dir_rows[i].top,
				dir_rows[i].bot, dir_rows[i].typed, res_t'{dir_rows[i].drive, dir_rows[i].gate,
				dir_rows[i].busy, dir_rows[i].flt});
		drain_results();

		// random phases; idling off for the zero-timeout setting and the last one
		for (int p = 0; p < N_PLAN; p++) begin
			load_regs(plan[p]);
			idle_on = (p != 1) && (p != N_PLAN - 1);
			run_random(105, (p == 0) ? 30 : -1);
			drain_results();
		end

		if (lift_out_q.size() != 0)
			flag_error($sformatf("%0d expected results never arrived", lift_out_q.size()));

		$display("covered %0d requests, %0d results, %0d register settings, %0d levels, %0d homings",
			n_req, n_res, n_settings, n_levels, n_homes);
		$display("fault pulses leave %0d, seek %0d, home %0d; long output hold-offs %0d",
			fault_hits[FAULT_LEAVE], fault_hits[FAULT_SEEK], fault_hits[FAULT_HOME], n_holds);
		if (n_err == 0)
			$display("tb_lift_level_stepper: done, clean");
		else
			$display("tb_lift_level_stepper: done, errors");
		$finish;
	end

	// hard stop if the handshakes ever hang
	initial begin : watchdog
		#1600000;
		$display("timeout after %0d requests and %0d results", n_req, n_res);
		$display("tb_lift_level_stepper: done, errors");
		$finish;
	end

endmodule
